### rtl/core/sppc_pkg.sv
// ----------------------------------------------------------------------------
// sppc_pkg
// Shared constants, types and helpers for the sphere pair collision pipeline.
// ----------------------------------------------------------------------------
package sppc_pkg;

  // vector format: three signed components, x in the low bits
  localparam int CB     = 21;
  localparam int FB     = 10;
  localparam int VW     = 3 * CB;
  localparam int DW     = CB + 1;           // component difference

  localparam int MASS_W = 16;
  localparam int RAD_W  = 16;
  localparam int BNC_W  = 17;
  localparam int SEP_W  = 16;
  localparam int TOT_W  = MASS_W + 1;
  localparam int BIGR_W = RAD_W + 1 + FB;   // (ra + rb) << FB
  localparam int E_W    = 2 * BNC_W - 16;   // restitution product, Q.16

  // squared distance, in units of 2^-(2*(FB+8))
  localparam int DSQ_W     = 2 * CB;
  localparam int SUM_W     = DSQ_W + 2;
  localparam int SQ_SHIFT  = 16;
  localparam int SEP_SHIFT = 8;

  // square root unit
  localparam int SQ_OUT_W     = 30;
  localparam int SQ_IN_W      = 2 * SQ_OUT_W;
  localparam int SQ_REM_W     = SQ_OUT_W + 2;
  localparam int SQ_PER_STAGE = 2;
  localparam int SQ_STAGES    = SQ_OUT_W / SQ_PER_STAGE;

  // divider unit
  localparam int DIV_D_W       = 28;
  localparam int DIV_Q_W       = 21;
  localparam int DIV_N_W       = DIV_D_W + DIV_Q_W;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = DIV_Q_W / DIV_PER_STAGE;

  // response math
  localparam int N_SHIFT = 28;              // normal numerator scale
  localparam int NF      = 20;              // normal fraction bits
  localparam int VF      = 16;              // velocity scale fraction bits
  localparam int PEN_W   = DIV_D_W + 1;
  localparam int N_W     = DIV_Q_W + 1;
  localparam int PROD_W  = DW + N_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int K_W     = DOT_W - NF + 1;
  localparam int KN_W    = K_W + N_W;
  localparam int X_W     = KN_W + 3;
  localparam int R_W     = 26;
  localparam int FP_W    = TOT_W + E_W;
  localparam int F_W     = FP_W - VF;
  localparam int VP_W    = R_W + F_W + 1;
  localparam int P_W     = CB + 2;

  localparam logic [TOT_W-1:0] RATIO_ONE = TOT_W'(1 << VF);

  // total register stages from input to output register
  localparam int PIPE_DEPTH = 3 + SQ_STAGES + 2 + DIV_STAGES + 7;

  localparam int IN_W  = 352;
  localparam int OUT_W = 256;

  localparam logic signed [63:0] C_MAX = (64'sd1 <<< (CB - 1)) - 64'sd1;
  localparam logic signed [63:0] C_MIN = -C_MAX - 64'sd1;

  typedef struct packed {
    logic [VW-1:0]         pa;
    logic [VW-1:0]         pb;
    logic [VW-1:0]         va;
    logic [VW-1:0]         vb;
    logic [2:0][DW-1:0]    d;
    logic [2:0][DW-1:0]    u;
    logic [MASS_W-1:0]     ma;
    logic [MASS_W-1:0]     mb;
    logic [TOT_W-1:0]      tot;
    logic [BIGR_W-1:0]     big_r;
    logic [BNC_W-1:0]      ba;
    logic [BNC_W-1:0]      bb;
    logic [E_W-1:0]        e;
    logic                  dyn_a;
    logic                  dyn_b;
    logic                  live;
    logic                  degen;
  } ctx_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_OUT_W-1:0] root;
    logic [SQ_IN_W-1:0]  x;
  } sq_st_t;

  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [DIV_Q_W-1:0] low;
    logic [DIV_Q_W-1:0] q;
    logic [DIV_D_W-1:0] den;
  } dv_st_t;

  // divide by 2^s, rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    q   = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [CB-1:0] clamp_c(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > C_MAX) c = C_MAX;
    if (v < C_MIN) c = C_MIN;
    return c[CB-1:0];
  endfunction

  function automatic logic over_c(input logic signed [63:0] v);
    return (v > C_MAX) || (v < C_MIN);
  endfunction

endpackage

### rtl/core/sphere_pair_collision_response.sv
// ----------------------------------------------------------------------------
// sphere_pair_collision_response
// Sphere/sphere contact test and impulse-style response, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: pair of spheres (352 bits)
//  m_*       out  m_tvalid/m_tready  m_tdata: new positions, velocities, flags
//  cfg_*     in   cfg_wr_en          cfg_wr_data: separation_distance
//
//  One pair per cycle unless the output stalls. The pipeline holds 3 setup
//  stages, 15 square root stages, 2 numerator stages, 7 divider stages and
//  7 response stages incl. the output register.
//  All stages advance together when the output register is empty or taken;
//  a stalled pipeline holds every stage, nothing is dropped or repeated.
//  rst (synchronous) clears the valid bits and separation_distance.
//
module sphere_pair_collision_response (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_a[62:0], pos_b[125:63], vel_a[188:126], vel_b[251:189],
  // mass_a[267:252], mass_b[283:268], radius_a[299:284], radius_b[315:300],
  // dynamic_a[316], dynamic_b[317], bounce_a[334:318], bounce_b[351:335]
  input  logic [sppc_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // new_pos_a[62:0], new_vel_a[125:63], new_pos_b[188:126],
  // new_vel_b[251:189], contact[252], degenerate[253], saturated[254], 0[255]
  output logic [sppc_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_wr_en,
  input  logic [sppc_pkg::SEP_W-1:0]    cfg_wr_data
);

  localparam int VW     = sppc_pkg::VW;
  localparam int CB     = sppc_pkg::CB;
  localparam int OFF_PA = 0;
  localparam int OFF_PB = OFF_PA + VW;
  localparam int OFF_VA = OFF_PB + VW;
  localparam int OFF_VB = OFF_VA + VW;
  localparam int OFF_MA = OFF_VB + VW;
  localparam int OFF_MB = OFF_MA + sppc_pkg::MASS_W;
  localparam int OFF_RA = OFF_MB + sppc_pkg::MASS_W;
  localparam int OFF_RB = OFF_RA + sppc_pkg::RAD_W;
  localparam int OFF_DA = OFF_RB + sppc_pkg::RAD_W;
  localparam int OFF_DB = OFF_DA + 1;
  localparam int OFF_BA = OFF_DB + 1;
  localparam int OFF_BB = OFF_BA + sppc_pkg::BNC_W;
  localparam int SQ_LAST = sppc_pkg::SQ_STAGES - 1;
  localparam int DV_LAST = sppc_pkg::DIV_STAGES - 1;

  // --------------------------------------------------------------------------
  // control: one valid bit per stage, global advance
  // --------------------------------------------------------------------------
  logic [sppc_pkg::PIPE_DEPTH-1:0] vld;
  logic                            adv;
  logic [sppc_pkg::SEP_W-1:0]      sep;

  assign adv      = !vld[sppc_pkg::PIPE_DEPTH-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[sppc_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[sppc_pkg::PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep <= '0;
    end else if (cfg_wr_en) begin
      sep <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage A: unpack, differences, radius sum
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t a_in, a_ctx;

  always_comb begin
    a_in    = '0;
    a_in.pa = s_tdata[OFF_PA +: VW];
    a_in.pb = s_tdata[OFF_PB +: VW];
    a_in.va = s_tdata[OFF_VA +: VW];
    a_in.vb = s_tdata[OFF_VB +: VW];
    for (int i = 0; i < 3; i++) begin
      a_in.d[i] = sppc_pkg::DW'($signed(a_in.pa[i*CB +: CB]))
                - sppc_pkg::DW'($signed(a_in.pb[i*CB +: CB]));
      a_in.u[i] = sppc_pkg::DW'($signed(a_in.va[i*CB +: CB]))
                - sppc_pkg::DW'($signed(a_in.vb[i*CB +: CB]));
    end
    a_in.ma    = s_tdata[OFF_MA +: sppc_pkg::MASS_W];
    a_in.mb    = s_tdata[OFF_MB +: sppc_pkg::MASS_W];
    a_in.tot   = {1'b0, a_in.ma} + {1'b0, a_in.mb};
    a_in.big_r = {({1'b0, s_tdata[OFF_RA +: sppc_pkg::RAD_W]}
                   + {1'b0, s_tdata[OFF_RB +: sppc_pkg::RAD_W]}),
                  sppc_pkg::FB'(0)};
    a_in.dyn_a = s_tdata[OFF_DA];
    a_in.dyn_b = s_tdata[OFF_DB];
    a_in.ba    = s_tdata[OFF_BA +: sppc_pkg::BNC_W];
    a_in.bb    = s_tdata[OFF_BB +: sppc_pkg::BNC_W];
  end

  always_ff @(posedge clk) begin
    if (adv) a_ctx <= a_in;
  end

  // --------------------------------------------------------------------------
  // stage B: squares
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                       b_ctx;
  logic signed [2*sppc_pkg::DW-1:0]     b_dsq_full [3];
  logic [sppc_pkg::DSQ_W-1:0]           b_dsq [3];
  logic [2*sppc_pkg::BIGR_W-1:0]        b_rsq;
  logic [2*sppc_pkg::BNC_W-1:0]         b_eprod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_dsq_full[i] = $signed(a_ctx.d[i]) * $signed(a_ctx.d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctx <= a_ctx;
      for (int i = 0; i < 3; i++) b_dsq[i] <= b_dsq_full[i][sppc_pkg::DSQ_W-1:0];
      b_rsq   <= a_ctx.big_r * a_ctx.big_r;
      b_eprod <= a_ctx.ba * a_ctx.bb;
    end
  end

  // --------------------------------------------------------------------------
  // stage C: squared distance, contact test, restitution
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                  c_in, c_ctx;
  logic [sppc_pkg::SUM_W-1:0]      c_sum;
  logic [sppc_pkg::SQ_IN_W-1:0]    c_rad_in, c_rad;
  logic [2*sppc_pkg::BNC_W:0]      c_eround;
  logic                            c_hit;

  always_comb begin
    c_sum    = sppc_pkg::SUM_W'(b_dsq[0]) + sppc_pkg::SUM_W'(b_dsq[1])
             + sppc_pkg::SUM_W'(b_dsq[2]);
    c_rad_in = {c_sum, sppc_pkg::SQ_SHIFT'(0)};
    c_hit    = c_rad_in <= sppc_pkg::SQ_IN_W'(b_rsq);
    c_eround = ({1'b0, b_eprod} + (2*sppc_pkg::BNC_W+1)'(1 << 15)) >> 16;
    c_in       = b_ctx;
    c_in.e     = c_eround[sppc_pkg::E_W-1:0];
    // coincident centers or massless pair: flag and pass through
    c_in.degen = c_hit && (c_sum == '0 || b_ctx.tot == '0);
    c_in.live  = c_hit && !c_in.degen;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctx <= c_in;
      c_rad <= c_rad_in;
    end
  end

  // --------------------------------------------------------------------------
  // square root of the squared distance, context runs alongside
  // --------------------------------------------------------------------------
  logic [sppc_pkg::SQ_OUT_W-1:0] sq_root;
  sppc_pkg::ctx_t                sq_ctx [sppc_pkg::SQ_STAGES];

  sppc_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (c_rad),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ctx[0] <= c_ctx;
      for (int j = 1; j < sppc_pkg::SQ_STAGES; j++) sq_ctx[j] <= sq_ctx[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage E: penetration plus separation
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                e_ctx;
  logic [sppc_pkg::DIV_D_W-1:0]  e_dist;
  logic [sppc_pkg::PEN_W-1:0]    e_pen;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ctx  <= sq_ctx[SQ_LAST];
      e_dist <= sq_root[sppc_pkg::DIV_D_W-1:0];
      e_pen  <= sppc_pkg::PEN_W'(sq_ctx[SQ_LAST].big_r)
              + (sppc_pkg::PEN_W'(sep) << sppc_pkg::SEP_SHIFT)
              - sppc_pkg::PEN_W'(sq_root[sppc_pkg::DIV_D_W-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // stage F: divider numerators (magnitudes, rounding half added)
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                f_ctx;
  logic [sppc_pkg::DW-1:0]       f_dneg [3];
  logic [sppc_pkg::DIV_Q_W-1:0]  f_mag [3];
  logic [sppc_pkg::DIV_N_W-1:0]  f_half;
  logic [sppc_pkg::DIV_N_W-1:0]  f_nnum [3];
  logic [sppc_pkg::DIV_N_W-1:0]  f_pnum [3];
  logic [sppc_pkg::DIV_N_W-1:0]  f_anum, f_bnum;
  logic [sppc_pkg::DIV_D_W-1:0]  f_dist, f_tot;

  always_comb begin
    f_half = sppc_pkg::DIV_N_W'(e_dist >> 1);
    for (int i = 0; i < 3; i++) begin
      f_dneg[i] = -e_ctx.d[i];
      f_mag[i]  = e_ctx.d[i][sppc_pkg::DW-1] ? f_dneg[i][sppc_pkg::DIV_Q_W-1:0]
                                              : e_ctx.d[i][sppc_pkg::DIV_Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_ctx <= e_ctx;
      for (int i = 0; i < 3; i++) begin
        f_nnum[i] <= {f_mag[i], sppc_pkg::N_SHIFT'(0)} + f_half;
        f_pnum[i] <= sppc_pkg::DIV_N_W'(f_mag[i]) * sppc_pkg::DIV_N_W'(e_pen) + f_half;
      end
      f_anum <= sppc_pkg::DIV_N_W'({e_ctx.mb, 16'h0000})
              + sppc_pkg::DIV_N_W'(e_ctx.tot >> 1);
      f_bnum <= sppc_pkg::DIV_N_W'({e_ctx.ma, 16'h0000})
              + sppc_pkg::DIV_N_W'(e_ctx.tot >> 1);
      f_tot  <= sppc_pkg::DIV_D_W'(e_ctx.tot);
      f_dist <= e_dist;
    end
  end

  // --------------------------------------------------------------------------
  // dividers: normal, push, mass ratios
  // --------------------------------------------------------------------------
  logic [sppc_pkg::DIV_Q_W-1:0] q_n [3];
  logic [sppc_pkg::DIV_Q_W-1:0] q_p [3];
  logic [sppc_pkg::DIV_Q_W-1:0] q_ra, q_rb;
  sppc_pkg::ctx_t               dv_ctx [sppc_pkg::DIV_STAGES];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sppc_div u_div_n (
      .clk (clk), .en (adv), .num (f_nnum[g]), .den (f_dist), .quo (q_n[g])
    );
    sppc_div u_div_p (
      .clk (clk), .en (adv), .num (f_pnum[g]), .den (f_dist), .quo (q_p[g])
    );
  end

  sppc_div u_div_ra (
    .clk (clk), .en (adv), .num (f_anum), .den (f_tot), .quo (q_ra)
  );
  sppc_div u_div_rb (
    .clk (clk), .en (adv), .num (f_bnum), .den (f_tot), .quo (q_rb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx[0] <= f_ctx;
      for (int j = 1; j < sppc_pkg::DIV_STAGES; j++) dv_ctx[j] <= dv_ctx[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage G: restore signs, pick mass ratios
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                   g_ctx;
  logic signed [sppc_pkg::N_W-1:0]  g_n [3];
  logic signed [sppc_pkg::N_W-1:0]  g_push [3];
  logic [sppc_pkg::TOT_W-1:0]       g_ra, g_rb;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_ctx <= dv_ctx[DV_LAST];
      for (int i = 0; i < 3; i++) begin
        g_n[i]    <= dv_ctx[DV_LAST].d[i][sppc_pkg::DW-1] ? -$signed({1'b0, q_n[i]})
                                                           : $signed({1'b0, q_n[i]});
        g_push[i] <= dv_ctx[DV_LAST].d[i][sppc_pkg::DW-1] ? -$signed({1'b0, q_p[i]})
                                                           : $signed({1'b0, q_p[i]});
      end
      g_ra <= dv_ctx[DV_LAST].dyn_b ? q_ra[sppc_pkg::TOT_W-1:0] : sppc_pkg::RATIO_ONE;
      g_rb <= dv_ctx[DV_LAST].dyn_a ? q_rb[sppc_pkg::TOT_W-1:0] : sppc_pkg::RATIO_ONE;
    end
  end

  // --------------------------------------------------------------------------
  // stage H: u . n partial products, ratio * e
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                      h_ctx;
  logic signed [sppc_pkg::PROD_W-1:0]  h_prod [3];
  logic signed [sppc_pkg::N_W-1:0]     h_n [3];
  logic signed [sppc_pkg::N_W-1:0]     h_push [3];
  logic [sppc_pkg::FP_W-1:0]           h_fa, h_fb;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_ctx <= g_ctx;
      for (int i = 0; i < 3; i++) begin
        h_prod[i] <= $signed(g_ctx.u[i]) * g_n[i];
        h_n[i]    <= g_n[i];
        h_push[i] <= g_push[i];
      end
      h_fa <= g_ra * g_ctx.e;
      h_fb <= g_rb * g_ctx.e;
    end
  end

  // --------------------------------------------------------------------------
  // stage I: dot product and its rounding, velocity factors
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                     i_ctx;
  logic signed [sppc_pkg::DOT_W-1:0]  i_dot;
  logic [sppc_pkg::FP_W:0]            i_fa_r, i_fb_r;
  logic signed [sppc_pkg::K_W-1:0]    i_k;
  logic signed [sppc_pkg::N_W-1:0]    i_n [3];
  logic signed [sppc_pkg::N_W-1:0]    i_push [3];
  logic [sppc_pkg::F_W-1:0]           i_fa, i_fb;

  always_comb begin
    i_dot  = h_prod[0] + h_prod[1] + h_prod[2];
    i_fa_r = ({1'b0, h_fa} + (sppc_pkg::FP_W+1)'(1 << 15)) >> sppc_pkg::VF;
    i_fb_r = ({1'b0, h_fb} + (sppc_pkg::FP_W+1)'(1 << 15)) >> sppc_pkg::VF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_ctx <= h_ctx;
      i_k   <= sppc_pkg::K_W'(sppc_pkg::rnd_shift(i_dot, sppc_pkg::NF));
      i_fa  <= i_fa_r[sppc_pkg::F_W-1:0];
      i_fb  <= i_fb_r[sppc_pkg::F_W-1:0];
      for (int i = 0; i < 3; i++) begin
        i_n[i]    <= h_n[i];
        i_push[i] <= h_push[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage J: k * n
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                     j_ctx;
  logic signed [sppc_pkg::KN_W-1:0]   j_kn [3];
  logic signed [sppc_pkg::N_W-1:0]    j_push [3];
  logic [sppc_pkg::F_W-1:0]           j_fa, j_fb;

  always_ff @(posedge clk) begin
    if (adv) begin
      j_ctx <= i_ctx;
      for (int i = 0; i < 3; i++) begin
        j_kn[i]   <= i_k * i_n[i];
        j_push[i] <= i_push[i];
      end
      j_fa <= i_fa;
      j_fb <= i_fb;
    end
  end

  // --------------------------------------------------------------------------
  // stage K: reflected relative velocity
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                    k_ctx;
  logic signed [sppc_pkg::X_W-1:0]   k_x [3];
  logic signed [sppc_pkg::R_W-1:0]   k_r [3];
  logic signed [sppc_pkg::N_W-1:0]   k_push [3];
  logic [sppc_pkg::F_W-1:0]          k_fa, k_fb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_x[i] = ($signed(j_ctx.u[i]) <<< sppc_pkg::NF) - (j_kn[i] <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_ctx <= j_ctx;
      for (int i = 0; i < 3; i++) begin
        k_r[i]    <= sppc_pkg::R_W'(sppc_pkg::rnd_shift(k_x[i], sppc_pkg::NF));
        k_push[i] <= j_push[i];
      end
      k_fa <= j_fa;
      k_fb <= j_fb;
    end
  end

  // --------------------------------------------------------------------------
  // stage L: scaled velocities, pushed positions
  // --------------------------------------------------------------------------
  sppc_pkg::ctx_t                    l_ctx;
  logic signed [sppc_pkg::VP_W-1:0]  l_vap [3];
  logic signed [sppc_pkg::VP_W-1:0]  l_vbp [3];
  logic signed [sppc_pkg::P_W-1:0]   l_tpa [3];
  logic signed [sppc_pkg::P_W-1:0]   l_tpb [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      l_ctx <= k_ctx;
      for (int i = 0; i < 3; i++) begin
        l_vap[i] <= k_r[i] * $signed({1'b0, k_fa});
        l_vbp[i] <= k_r[i] * $signed({1'b0, k_fb});
        l_tpa[i] <= $signed(k_ctx.pa[i*CB +: CB]) + k_push[i];
        l_tpb[i] <= $signed(k_ctx.pb[i*CB +: CB]) - k_push[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage M: round, clamp, select pass-through, output register
  // --------------------------------------------------------------------------
  logic signed [63:0]  m_va [3];
  logic signed [63:0]  m_vb [3];
  logic [VW-1:0]       m_pa_c, m_va_c, m_pb_c, m_vb_c;
  logic                m_ov_a, m_ov_b;
  logic                m_app_a, m_app_b;
  logic [sppc_pkg::OUT_W-1:0] m_next, m_data;

  always_comb begin
    m_ov_a = 1'b0;
    m_ov_b = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m_va[i] = sppc_pkg::rnd_shift(l_vap[i], sppc_pkg::VF);
      m_vb[i] = -sppc_pkg::rnd_shift(l_vbp[i], sppc_pkg::VF);
      m_pa_c[i*CB +: CB] = sppc_pkg::clamp_c(l_tpa[i]);
      m_pb_c[i*CB +: CB] = sppc_pkg::clamp_c(l_tpb[i]);
      m_va_c[i*CB +: CB] = sppc_pkg::clamp_c(m_va[i]);
      m_vb_c[i*CB +: CB] = sppc_pkg::clamp_c(m_vb[i]);
      m_ov_a = m_ov_a | sppc_pkg::over_c(l_tpa[i]) | sppc_pkg::over_c(m_va[i]);
      m_ov_b = m_ov_b | sppc_pkg::over_c(l_tpb[i]) | sppc_pkg::over_c(m_vb[i]);
    end
    // a static sphere keeps its values and never counts as saturated
    m_app_a = l_ctx.live && l_ctx.dyn_a;
    m_app_b = l_ctx.live && l_ctx.dyn_b;
    m_next  = '0;
    m_next[0*VW +: VW] = m_app_a ? m_pa_c : l_ctx.pa;
    m_next[1*VW +: VW] = m_app_a ? m_va_c : l_ctx.va;
    m_next[2*VW +: VW] = m_app_b ? m_pb_c : l_ctx.pb;
    m_next[3*VW +: VW] = m_app_b ? m_vb_c : l_ctx.vb;
    m_next[4*VW]       = l_ctx.live;
    m_next[4*VW + 1]   = l_ctx.degen;
    m_next[4*VW + 2]   = (m_app_a && m_ov_a) || (m_app_b && m_ov_b);
  end

  always_ff @(posedge clk) begin
    if (adv) m_data <= m_next;
  end

  assign m_tdata = m_data;

endmodule

### rtl/core/sppc_sqrt.sv
// ----------------------------------------------------------------------------
// sppc_sqrt
// Pipelined floor square root, two result bits per stage.
// ----------------------------------------------------------------------------
module sppc_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [sppc_pkg::SQ_IN_W-1:0]   radicand,
  output logic [sppc_pkg::SQ_OUT_W-1:0]  root
);

  sppc_pkg::sq_st_t st [sppc_pkg::SQ_STAGES];
  sppc_pkg::sq_st_t init;

  function automatic sppc_pkg::sq_st_t sq_stage(input sppc_pkg::sq_st_t s);
    sppc_pkg::sq_st_t                o;
    logic [sppc_pkg::SQ_REM_W-1:0]   t;
    logic [sppc_pkg::SQ_REM_W-1:0]   trial;
    o = s;
    for (int k = 0; k < sppc_pkg::SQ_PER_STAGE; k++) begin
      t     = {o.rem[sppc_pkg::SQ_REM_W-3:0], o.x[sppc_pkg::SQ_IN_W-1 -: 2]};
      trial = {o.root, 2'b01};
      o.x   = o.x << 2;
      if (t >= trial) begin
        o.rem  = t - trial;
        o.root = {o.root[sppc_pkg::SQ_OUT_W-2:0], 1'b1};
      end else begin
        o.rem  = t;
        o.root = {o.root[sppc_pkg::SQ_OUT_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.x    = radicand;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_stage(init);
      for (int j = 1; j < sppc_pkg::SQ_STAGES; j++) begin
        st[j] <= sq_stage(st[j-1]);
      end
    end
  end

  assign root = st[sppc_pkg::SQ_STAGES-1].root;

endmodule

### rtl/core/sppc_div.sv
// ----------------------------------------------------------------------------
// sppc_div
// Pipelined restoring divider, three quotient bits per stage.
// Expects num < den * 2^DIV_Q_W.
// ----------------------------------------------------------------------------
module sppc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sppc_pkg::DIV_N_W-1:0]  num,
  input  logic [sppc_pkg::DIV_D_W-1:0]  den,
  output logic [sppc_pkg::DIV_Q_W-1:0]  quo
);

  sppc_pkg::dv_st_t st [sppc_pkg::DIV_STAGES];
  sppc_pkg::dv_st_t init;

  function automatic sppc_pkg::dv_st_t dv_stage(input sppc_pkg::dv_st_t s);
    sppc_pkg::dv_st_t              o;
    logic [sppc_pkg::DIV_D_W:0]    t;
    o = s;
    for (int k = 0; k < sppc_pkg::DIV_PER_STAGE; k++) begin
      t     = {o.rem, o.low[sppc_pkg::DIV_Q_W-1]};
      o.low = o.low << 1;
      if (t >= {1'b0, o.den}) begin
        t     = t - {1'b0, o.den};
        o.q   = {o.q[sppc_pkg::DIV_Q_W-2:0], 1'b1};
      end else begin
        o.q   = {o.q[sppc_pkg::DIV_Q_W-2:0], 1'b0};
      end
      o.rem = t[sppc_pkg::DIV_D_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    init.rem = num[sppc_pkg::DIV_N_W-1:sppc_pkg::DIV_Q_W];
    init.low = num[sppc_pkg::DIV_Q_W-1:0];
    init.q   = '0;
    init.den = den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= dv_stage(init);
      for (int j = 1; j < sppc_pkg::DIV_STAGES; j++) begin
        st[j] <= dv_stage(st[j-1]);
      end
    end
  end

  assign quo = st[sppc_pkg::DIV_STAGES-1].q;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sphere_pair_collision_response: a bit-exact
// predictor runs beside the pipeline and every output transfer is compared.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [16:0] bb;
    logic [16:0] ba;
    logic        dyn_b;
    logic        dyn_a;
    logic [15:0] rb;
    logic [15:0] ra;
    logic [15:0] mb;
    logic [15:0] ma;
    logic [62:0] vb;
    logic [62:0] va;
    logic [62:0] pb;
    logic [62:0] pa;
  } pair_t;

  typedef struct packed {
    logic        pad;
    logic        saturated;
    logic        degenerate;
    logic        contact;
    logic [62:0] vb;
    logic [62:0] pb;
    logic [62:0] va;
    logic [62:0] pa;
  } response_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [sppc_pkg::IN_W-1:0]    s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [sppc_pkg::OUT_W-1:0]   m_tdata;
  logic                         cfg_wr_en;
  logic [sppc_pkg::SEP_W-1:0]   cfg_wr_data;

  logic [15:0] sep_dist;          // shadow of the register
  response_t   expected_q[$];
  int          tx_idle_pct, rx_idle_pct;
  int          n_errors, n_checked, n_contact, n_degen, n_sat;

  sphere_pair_collision_response dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint div_round(longint n, longint d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : n;
    q   = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint comp(logic [62:0] w, int i);
    return longint'($signed(w[i*21 +: 21]));
  endfunction

  function automatic logic [62:0] pack_clamped(longint c[3], inout logic sat);
    logic [62:0] w;
    longint v;
    w = '0;
    for (int i = 0; i < 3; i++) begin
      v = c[i];
      if (v > 1048575)  begin v = 1048575;  sat = 1'b1; end
      if (v < -1048576) begin v = -1048576; sat = 1'b1; end
      w[i*21 +: 21] = v[20:0];
    end
    return w;
  endfunction

  function automatic response_t predict_response(pair_t p, logic [15:0] sep);
    longint pa[3], pb[3], va[3], vb[3], d[3], nrm[3], push[3], r[3];
    longint unsigned sum, big_r, dist_len;
    longint pen, dot, k, e, fa, fb, tot;
    logic sat;
    response_t res;
    sat = 1'b0;
    res = '0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      pa[i] = comp(p.pa, i); pb[i] = comp(p.pb, i);
      va[i] = comp(p.va, i); vb[i] = comp(p.vb, i);
      d[i]  = pa[i] - pb[i];
      sum  += longint'(d[i] * 256 * d[i] * 256);
    end
    big_r = (longint'(p.ra) + longint'(p.rb)) << 10;
    if (sum <= big_r * big_r) begin
      tot = longint'(p.ma) + longint'(p.mb);
      if (sum == 0 || tot == 0) begin
        res.degenerate = 1'b1;
      end else begin
        res.contact = 1'b1;
        dist_len = int_sqrt(sum);
        pen  = longint'(big_r) - longint'(dist_len) + longint'(sep) * 256;
        dot  = 0;
        for (int i = 0; i < 3; i++) begin
          nrm[i]  = div_round(d[i] * (64'sd1 << 28), dist_len);
          push[i] = div_round(d[i] * pen, dist_len);
          dot    += (va[i] - vb[i]) * nrm[i];
        end
        k = div_round(dot, 64'sd1 << 20);
        for (int i = 0; i < 3; i++)
          r[i] = div_round((va[i] - vb[i]) * (64'sd1 << 20) - 2 * k * nrm[i],
                           64'sd1 << 20);
        e  = div_round(longint'(p.ba) * longint'(p.bb), 64'sd1 << 16);
        fa = p.dyn_b ? div_round(longint'(p.mb) * 65536, tot) : 65536;
        fb = p.dyn_a ? div_round(longint'(p.ma) * 65536, tot) : 65536;
        fa = div_round(fa * e, 64'sd1 << 16);
        fb = div_round(fb * e, 64'sd1 << 16);
        if (p.dyn_a)
          for (int i = 0; i < 3; i++) begin
            pa[i] = pa[i] + push[i];
            va[i] = div_round(r[i] * fa, 64'sd1 << 16);
          end
        if (p.dyn_b)
          for (int i = 0; i < 3; i++) begin
            pb[i] = pb[i] - push[i];
            vb[i] = div_round(-r[i] * fb, 64'sd1 << 16);
          end
      end
    end
    res.pa = pack_clamped(pa, sat);
    res.va = pack_clamped(va, sat);
    res.pb = pack_clamped(pb, sat);
    res.vb = pack_clamped(vb, sat);
    res.saturated = sat;
    return res;
  endfunction

  // ------------------------------------------------------------ stimulus side
  function automatic logic [62:0] vec3(longint x, longint y, longint z);
    logic [62:0] w;
    w[20:0]  = x[20:0];
    w[41:21] = y[20:0];
    w[62:42] = z[20:0];
    return w;
  endfunction

  function automatic longint rand_c(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  // one input transfer; called at a falling edge, returns at a falling edge
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
    expected_q = {expected_q, predict_response(p, sep_dist)};
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);     // pipeline is 34 deep
  endtask

  task automatic write_separation(logic [15:0] value);
    drain_and_settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sep_dist     = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int    kind;
    longint x, y, z, span;
    kind = $urandom_range(99);
    p.va = 63'({$urandom, $urandom});
    p.vb = 63'({$urandom, $urandom});
    p.ma = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom);
    p.mb = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom);
    p.dyn_a = 1'($urandom_range(1));
    p.dyn_b = 1'($urandom_range(1));
    p.ba = 17'($urandom_range(65536));
    p.bb = 17'($urandom_range(65536));
    if (kind < 20) begin
      // raw noise, mostly no contact
      p.pa = 63'({$urandom, $urandom});
      p.pb = 63'({$urandom, $urandom});
      p.ra = 16'($urandom);
      p.rb = 16'($urandom);
    end else begin
      // near pair: offset sized so most pairs touch
      x = rand_c(longint'(1) << 19);
      y = rand_c(longint'(1) << 19);
      z = rand_c(longint'(1) << 19);
      p.pa = vec3(x, y, z);
      span = longint'(1) << $urandom_range(16, 4);
      p.pb = (kind < 25) ? p.pa :
             vec3(x + rand_c(span), y + rand_c(span), z + rand_c(span));
      p.ra = 16'($urandom_range(32'(span >> 2), 0));
      p.rb = 16'($urandom_range(32'(span >> 2), 0));
      if (kind > 95) begin
        p.ra = 16'($urandom);
        p.rb = 16'($urandom);
      end
    end
    return p;
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_directed();
    pair_t p;
    pair_t base;
    base.pa = vec3(1024, 0, 0);
    base.pb = vec3(0, 0, 0);
    base.va = vec3(-2048, 512, 0);
    base.vb = vec3(1024, 0, -300);
    base.ma = 16'h0100; base.mb = 16'h0300;
    base.ra = 16'h0100; base.rb = 16'h0100;
    base.dyn_a = 1'b1; base.dyn_b = 1'b1;
    base.ba = 17'd65536; base.bb = 17'd65536;
    send_pair(base);                                      // plain contact
    p = base; p.pa = vec3(5000, 0, 0);  send_pair(p);     // no contact
    p = base; p.ra = 16'h0200; p.rb = 16'h0200; p.pa = vec3(4096, 0, 0);
    send_pair(p);                                         // touching exactly
    p = base; p.pb = p.pa;               send_pair(p);    // coincident centers
    p = base; p.ma = '0; p.mb = '0;      send_pair(p);    // zero total mass
    p = base; p.dyn_a = 1'b0;            send_pair(p);    // A static
    p = base; p.dyn_b = 1'b0;            send_pair(p);    // B static
    p = base; p.dyn_a = 1'b0; p.dyn_b = 1'b0; send_pair(p); // both static
    p = base; p.ba = '0;                 send_pair(p);    // no bounce
    p = base; p.ba = 17'd65536; p.bb = 17'd65536; p.ma = 16'hFFFF; p.mb = 16'hFFFF;
    send_pair(p);
    p = base; p.ra = 16'hFFFF; p.rb = 16'hFFFF;
    p.pa = vec3(1048575, -1048576, 1048575); p.pb = vec3(-1048576, 1048575, -1048576);
    p.va = vec3(1048575, 1048575, -1048576); p.vb = vec3(-1048576, -1048576, 1048575);
    send_pair(p);                                         // extremes, saturation
    p = base; p.pa = '1; p.pb = '1; p.va = '1; p.vb = '1;
    p.ma = '1; p.mb = '1; p.ra = '1; p.rb = '1;
    send_pair(p);
    p = '0;                              send_pair(p);    // all zero
    p = base; p.ra = 16'hFFFF; p.rb = 16'hFFFF;
    p.pa = vec3(1048000, 3, -7); p.pb = vec3(1047000, 0, 0);
    send_pair(p);                                         // push past range
    p = base; p.pa = vec3(1, 0, 0); p.ra = '0; p.rb = '0; send_pair(p);
    p = base; p.pa = vec3(0, 0, 1); p.ra = '0; p.rb = 16'd1; send_pair(p);
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(random_pair());
  endtask

  task automatic test_separation_sweep();
    write_separation(16'hFFFF);
    test_directed();
    test_random(40);
    write_separation(16'($urandom));
    test_random(40);
    write_separation(16'd0);
  endtask

  // ------------------------------------------------------------ result check
  always @(negedge clk)
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    response_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        n_contact += want.contact;
        n_degen   += want.degenerate;
        n_sat     += want.saturated;
        if (got.pa !== want.pa)
          $display("%0t: new_pos_a expected %h actual %h", $time, want.pa, got.pa);
        if (got.va !== want.va)
          $display("%0t: new_vel_a expected %h actual %h", $time, want.va, got.va);
        if (got.pb !== want.pb)
          $display("%0t: new_pos_b expected %h actual %h", $time, want.pb, got.pb);
        if (got.vb !== want.vb)
          $display("%0t: new_vel_b expected %h actual %h", $time, want.vb, got.vb);
        if (got.contact !== want.contact)
          $display("%0t: contact expected %b actual %b", $time,
                   want.contact, got.contact);
        if (got.degenerate !== want.degenerate)
          $display("%0t: degenerate expected %b actual %b", $time,
                   want.degenerate, got.degenerate);
        if (got.saturated !== want.saturated)
          $display("%0t: saturated expected %b actual %b", $time,
                   want.saturated, got.saturated);
        if (got.pad !== 1'b0)
          $display("%0t: pad bit expected 0 actual %b", $time, got.pad);
        if (got !== want) n_errors++;
      end
    end
  end

  // ------------------------------------------------------------------ main
  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    sep_dist = '0;
    n_errors = 0; n_checked = 0; n_contact = 0; n_degen = 0; n_sat = 0;
    tx_idle_pct = 34; rx_idle_pct = 60;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();                  // register still at its reset value
    test_random(110);
    tx_idle_pct = 60; rx_idle_pct = 34;
    test_separation_sweep();
    test_random(110);
    tx_idle_pct = 0; rx_idle_pct = 0;
    write_separation(16'd512);
    test_random(110);

    drain_and_settle();
    $display("checked %0d results: %0d contacts, %0d degenerate, %0d saturated",
             n_checked, n_contact, n_degen, n_sat);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[sphere_pair_collision_response] OK");
    end else begin
      $display("[sphere_pair_collision_response] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("[sphere_pair_collision_response] ERROR");
    $finish;
  end

endmodule
